FILE: sv/sst_pkg.sv
// Shared types, constants and the load classification function of the smoothed stiffness index tracker.
package sst_pkg;

  localparam int FREQ_W   = 16;
  localparam int POWER_W  = 32;
  localparam int HEALTH_W = 15;
  localparam int INDEX_W  = 12;
  localparam int STATUS_W = 2;
  localparam int CLASS_W  = 2;

  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 5;
  localparam int REG_SEL_W = 3;

  // Register indexes on the configuration port
  localparam logic [REG_SEL_W-1:0] REG_POWER_FLOOR   = 3'd0;
  localparam logic [REG_SEL_W-1:0] REG_BAND_LOW      = 3'd1;
  localparam logic [REG_SEL_W-1:0] REG_BAND_HIGH     = 3'd2;
  localparam logic [REG_SEL_W-1:0] REG_HEALTHY       = 3'd3;
  localparam logic [REG_SEL_W-1:0] REG_FULL_THRESH   = 3'd4;
  localparam logic [REG_SEL_W-1:0] REG_PARTIAL_THRESH = 3'd5;

  localparam logic [POWER_W-1:0]  RST_POWER_FLOOR    = 32'd1;
  localparam logic [FREQ_W-1:0]   RST_BAND_LOW       = 16'd1280;
  localparam logic [FREQ_W-1:0]   RST_BAND_HIGH      = 16'd25600;
  localparam logic [HEALTH_W-1:0] RST_HEALTHY        = 15'd5120;
  localparam logic [INDEX_W-1:0]  RST_FULL_THRESH    = 12'd1280;
  localparam logic [INDEX_W-1:0]  RST_PARTIAL_THRESH = 12'd800;

  localparam logic [HEALTH_W-1:0] HEALTHY_MIN = 15'd65;
  localparam logic [HEALTH_W-1:0] HEALTHY_MAX = 15'd31999;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_LOW_POWER  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OUT_BAND   = 2'd2;

  // Load classes
  localparam logic [CLASS_W-1:0] CLASS_NON     = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_PARTIAL = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_FULL    = 2'd2;

  // Smoothing: (77*f + 179*s + 128) >> 8
  localparam int SMOOTH_SUM_W  = 24;
  localparam int SMOOTH_SHIFT  = 8;
  localparam logic [7:0] WEIGHT_NEW  = 8'd77;
  localparam logic [7:0] WEIGHT_OLD  = 8'd179;
  localparam logic [7:0] SMOOTH_ROUND = 8'd128;

  // Index: s*s*1600 / (h*h), saturated at 3200
  localparam int SQ_W     = 2 * FREQ_W;
  localparam int HSQ_W    = 2 * HEALTH_W;
  localparam int NUM_W    = SQ_W + 11;
  localparam int CNT_W    = 4;
  localparam logic [10:0] INDEX_SCALE = 11'd1600;
  localparam logic [INDEX_W-1:0] INDEX_MAX = 12'd3200;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [POWER_W-1:0]  power_floor;
    logic [FREQ_W-1:0]   band_low_freq;
    logic [FREQ_W-1:0]   band_high_freq;
    logic [HEALTH_W-1:0] healthy_freq;
    logic [INDEX_W-1:0]  full_load_threshold;
    logic [INDEX_W-1:0]  partial_load_threshold;
  } cfg_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FREQ_W-1:0]   freq;
  } entry_t;

  function automatic logic [CLASS_W-1:0] classify(
    input logic [INDEX_W-1:0] idx,
    input logic [INDEX_W-1:0] full_thr,
    input logic [INDEX_W-1:0] partial_thr
  );
    logic [CLASS_W-1:0] cls;
    priority if (idx >= full_thr) begin
      cls = CLASS_FULL;
    end else if (idx >= partial_thr) begin
      cls = CLASS_PARTIAL;
    end else begin
      cls = CLASS_NON;
    end
    return cls;
  endfunction

endpackage

FILE: sv/sst_regs.sv
// Configuration registers behind the APB-style port.
module sst_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sst_pkg::ADDR_W-1:0]    paddr,
  input  logic [sst_pkg::DATA_W-1:0]    pwdata,
  output logic [sst_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  output sst_pkg::cfg_t                 cfg
);

  logic [sst_pkg::REG_SEL_W-1:0] sel;
  logic                          wr;
  logic [sst_pkg::HEALTH_W-1:0]  healthy_wr;

  assign pready     = 1'b1;
  assign sel        = paddr[sst_pkg::ADDR_W-1:2];
  assign wr         = psel && penable && pwrite && pready;
  assign healthy_wr = pwdata[sst_pkg::HEALTH_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.power_floor            <= sst_pkg::RST_POWER_FLOOR;
      cfg.band_low_freq          <= sst_pkg::RST_BAND_LOW;
      cfg.band_high_freq         <= sst_pkg::RST_BAND_HIGH;
      cfg.healthy_freq           <= sst_pkg::RST_HEALTHY;
      cfg.full_load_threshold    <= sst_pkg::RST_FULL_THRESH;
      cfg.partial_load_threshold <= sst_pkg::RST_PARTIAL_THRESH;
    end else if (wr) begin
      unique case (sel)
        sst_pkg::REG_POWER_FLOOR: begin
          cfg.power_floor <= pwdata;
        end
        sst_pkg::REG_BAND_LOW: begin
          cfg.band_low_freq <= pwdata[sst_pkg::FREQ_W-1:0];
        end
        sst_pkg::REG_BAND_HIGH: begin
          cfg.band_high_freq <= pwdata[sst_pkg::FREQ_W-1:0];
        end
        sst_pkg::REG_HEALTHY: begin
          // drop values that would make the reference out of range
          if (healthy_wr >= sst_pkg::HEALTHY_MIN && healthy_wr <= sst_pkg::HEALTHY_MAX) begin
            cfg.healthy_freq <= healthy_wr;
          end
        end
        sst_pkg::REG_FULL_THRESH: begin
          cfg.full_load_threshold <= pwdata[sst_pkg::INDEX_W-1:0];
        end
        sst_pkg::REG_PARTIAL_THRESH: begin
          cfg.partial_load_threshold <= pwdata[sst_pkg::INDEX_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      sst_pkg::REG_POWER_FLOOR:    prdata = cfg.power_floor;
      sst_pkg::REG_BAND_LOW:       prdata = sst_pkg::DATA_W'(cfg.band_low_freq);
      sst_pkg::REG_BAND_HIGH:      prdata = sst_pkg::DATA_W'(cfg.band_high_freq);
      sst_pkg::REG_HEALTHY:        prdata = sst_pkg::DATA_W'(cfg.healthy_freq);
      sst_pkg::REG_FULL_THRESH:    prdata = sst_pkg::DATA_W'(cfg.full_load_threshold);
      sst_pkg::REG_PARTIAL_THRESH: prdata = sst_pkg::DATA_W'(cfg.partial_load_threshold);
      default:                     prdata = '0;
    endcase
  end

endmodule

FILE: sv/sst_front.sv
// Front end: takes peak estimates and gates them on power and frequency band.
module sst_front (
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [sst_pkg::FREQ_W-1:0]    peak_freq,
  input  logic [sst_pkg::POWER_W-1:0]   peak_power,
  input  sst_pkg::cfg_t                 cfg,
  input  logic                          q_full,
  output logic                          q_push,
  output sst_pkg::entry_t               q_wdata
);

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_wdata.freq = peak_freq;
    // power check wins over the band check
    priority if (peak_power < cfg.power_floor) begin
      q_wdata.status = sst_pkg::STATUS_LOW_POWER;
    end else if (peak_freq < cfg.band_low_freq || peak_freq > cfg.band_high_freq) begin
      q_wdata.status = sst_pkg::STATUS_OUT_BAND;
    end else begin
      q_wdata.status = sst_pkg::STATUS_OK;
    end
  end

endmodule

FILE: sv/sst_queue.sv
// Short request queue between the front end and the back end.
module sst_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  sst_pkg::entry_t wdata,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output sst_pkg::entry_t rdata
);

  sst_pkg::entry_t                 slots [sst_pkg::QUEUE_DEPTH];
  logic [sst_pkg::QPTR_W-1:0]      wr_ptr;
  logic [sst_pkg::QPTR_W-1:0]      rd_ptr;
  logic [sst_pkg::QCNT_W-1:0]      count;

  assign full      = (count == sst_pkg::QCNT_W'(sst_pkg::QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign rdata     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == sst_pkg::QPTR_W'(sst_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == sst_pkg::QPTR_W'(sst_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: sv/sst_back.sv
// Back end: smoothing, index division, classification and the result register.
module sst_back (
  input  logic                          clk,
  input  logic                          rst,
  input  sst_pkg::cfg_t                 cfg,
  input  logic                          q_not_empty,
  input  sst_pkg::entry_t               q_rdata,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sst_pkg::STATUS_W-1:0]  status,
  output logic [sst_pkg::FREQ_W-1:0]    smoothed_freq,
  output logic [sst_pkg::INDEX_W-1:0]   stiffness_index,
  output logic [sst_pkg::CLASS_W-1:0]   load_class
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SMOOTH,
    ST_SQUARE,
    ST_SCALE,
    ST_CHECK,
    ST_DIV
  } state_t;

  state_t                          state;
  logic                            primed;
  logic [sst_pkg::FREQ_W-1:0]      smoothed;
  logic [sst_pkg::INDEX_W-1:0]     index_value;
  logic [sst_pkg::FREQ_W-1:0]      freq;
  logic [sst_pkg::SQ_W-1:0]        sq;
  logic [sst_pkg::HSQ_W-1:0]       hsq;
  logic [sst_pkg::NUM_W-1:0]       num;
  logic [sst_pkg::NUM_W-1:0]       limit;
  logic [sst_pkg::NUM_W-1:0]       divisor;
  logic [sst_pkg::INDEX_W-1:0]     quot;
  logic [sst_pkg::CNT_W-1:0]       cnt;

  logic                            out_free;
  logic [sst_pkg::SMOOTH_SUM_W-1:0] smooth_sum;
  logic                            div_fit;
  logic [sst_pkg::INDEX_W-1:0]     quot_next;
  logic                            result_load;

  assign out_free = !out_valid || !out_stall;
  assign q_pop    = (state == ST_IDLE) && q_not_empty && out_free;

  // a new result enters the output register this cycle
  assign result_load = (q_pop && q_rdata.status != sst_pkg::STATUS_OK)
                     || (state == ST_CHECK && num >= limit)
                     || (state == ST_DIV && cnt == '0);

  assign smooth_sum = sst_pkg::SMOOTH_SUM_W'(freq) * sst_pkg::SMOOTH_SUM_W'(sst_pkg::WEIGHT_NEW)
                    + sst_pkg::SMOOTH_SUM_W'(smoothed) * sst_pkg::SMOOTH_SUM_W'(sst_pkg::WEIGHT_OLD)
                    + sst_pkg::SMOOTH_SUM_W'(sst_pkg::SMOOTH_ROUND);

  assign div_fit   = (num >= divisor);
  assign quot_next = {quot[sst_pkg::INDEX_W-2:0], div_fit};

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      primed      <= 1'b0;
      smoothed    <= '0;
      index_value <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (result_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_pop) begin
            if (q_rdata.status == sst_pkg::STATUS_OK) begin
              freq  <= q_rdata.freq;
              state <= ST_SMOOTH;
            end else begin
              // rejected: report unchanged state
              status          <= q_rdata.status;
              smoothed_freq   <= smoothed;
              stiffness_index <= index_value;
              load_class      <= sst_pkg::classify(index_value, cfg.full_load_threshold,
                                                   cfg.partial_load_threshold);
            end
          end
        end
        ST_SMOOTH: begin
          smoothed <= primed ? smooth_sum[sst_pkg::SMOOTH_SUM_W-1:sst_pkg::SMOOTH_SHIFT] : freq;
          primed   <= 1'b1;
          state    <= ST_SQUARE;
        end
        ST_SQUARE: begin
          sq    <= sst_pkg::SQ_W'(smoothed) * sst_pkg::SQ_W'(smoothed);
          hsq   <= sst_pkg::HSQ_W'(cfg.healthy_freq) * sst_pkg::HSQ_W'(cfg.healthy_freq);
          state <= ST_SCALE;
        end
        ST_SCALE: begin
          num     <= sst_pkg::NUM_W'(sq) * sst_pkg::NUM_W'(sst_pkg::INDEX_SCALE);
          limit   <= sst_pkg::NUM_W'(hsq) * sst_pkg::NUM_W'(sst_pkg::INDEX_MAX);
          divisor <= sst_pkg::NUM_W'(hsq) << (sst_pkg::INDEX_W - 1);
          state   <= ST_CHECK;
        end
        ST_CHECK: begin
          if (num >= limit) begin
            // saturate without dividing
            index_value     <= sst_pkg::INDEX_MAX;
            status          <= sst_pkg::STATUS_OK;
            smoothed_freq   <= smoothed;
            stiffness_index <= sst_pkg::INDEX_MAX;
            load_class      <= sst_pkg::classify(sst_pkg::INDEX_MAX, cfg.full_load_threshold,
                                                 cfg.partial_load_threshold);
            state           <= ST_IDLE;
          end else begin
            quot  <= '0;
            cnt   <= sst_pkg::CNT_W'(sst_pkg::INDEX_W - 1);
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          // one quotient bit per cycle, most significant first
          if (div_fit) begin
            num <= num - divisor;
          end
          divisor <= divisor >> 1;
          quot    <= quot_next;
          cnt     <= cnt - 1'b1;
          if (cnt == '0) begin
            index_value     <= quot_next;
            status          <= sst_pkg::STATUS_OK;
            smoothed_freq   <= smoothed;
            stiffness_index <= quot_next;
            load_class      <= sst_pkg::classify(quot_next, cfg.full_load_threshold,
                                                 cfg.partial_load_threshold);
            state           <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: sv/smoothed_stiffness_index_tracker.sv
// Smoothed stiffness index tracker: top level.
// Each peak estimate (peak_freq in Q10.6 Hz, peak_power) gives exactly one result. An estimate
// below the power floor or outside the frequency band is rejected and its result is loaded
// into the result register as it is dequeued, with the current smoothed frequency, index and class.
// An accepted estimate updates the smoothed frequency and recomputes the index through a
// restoring divider that yields one quotient bit per cycle; it passes through the back end
// in order (dequeue, smooth, square, scale, saturation check, then 12 divide steps), and the
// divide steps are skipped when the index saturates. A result that waits on out_stall holds
// the back end, so the next request is dequeued only once it is taken.
// A two-entry queue sits between the gating front end and the back end, and a result
// register on the output lets new estimates enter while a result waits to be taken.
module smoothed_stiffness_index_tracker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sst_pkg::ADDR_W-1:0]    paddr,
  input  logic [sst_pkg::DATA_W-1:0]    pwdata,
  output logic [sst_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [sst_pkg::FREQ_W-1:0]    peak_freq,
  input  logic [sst_pkg::POWER_W-1:0]   peak_power,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sst_pkg::STATUS_W-1:0]  status,
  output logic [sst_pkg::FREQ_W-1:0]    smoothed_freq,
  output logic [sst_pkg::INDEX_W-1:0]   stiffness_index,
  output logic [sst_pkg::CLASS_W-1:0]   load_class
);

  sst_pkg::cfg_t   cfg;
  logic            q_full;
  logic            q_push;
  logic            q_pop;
  logic            q_not_empty;
  sst_pkg::entry_t q_wdata;
  sst_pkg::entry_t q_rdata;

  sst_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sst_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .peak_freq  (peak_freq),
    .peak_power (peak_power),
    .cfg        (cfg),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_wdata    (q_wdata)
  );

  sst_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .wdata     (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .rdata     (q_rdata)
  );

  sst_back u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .q_not_empty     (q_not_empty),
    .q_rdata         (q_rdata),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status          (status),
    .smoothed_freq   (smoothed_freq),
    .stiffness_index (stiffness_index),
    .load_class      (load_class)
  );

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the smoothed stiffness index tracker.
`timescale 1ns / 1ps

module tb_top;
  import sst_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FREQ_W-1:0]   freq;
    logic [INDEX_W-1:0]  index;
    logic [CLASS_W-1:0]  load_cls;
  } track_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [FREQ_W-1:0]   peak_freq = '0;
  logic [POWER_W-1:0]  peak_power = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [FREQ_W-1:0]   smoothed_freq;
  logic [INDEX_W-1:0]  stiffness_index;
  logic [CLASS_W-1:0]  load_class;

  // Tracker state as the testbench sees it
  cfg_t               model_cfg;
  logic [FREQ_W-1:0]  trk_smoothed;
  logic               trk_primed;
  logic [INDEX_W-1:0] trk_index;
  track_result_t      pending_results[$];

  int  fail_count = 0;
  int  quiet_cycles = 0;
  bit  src_gaps = 1'b0;
  bit  sink_gaps = 1'b0;
  int  hold_req = 0;
  int  hold_left = 0;
  int  burst_left = 0;
  int  calm_left = 0;

  smoothed_stiffness_index_tracker dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .peak_freq(peak_freq), .peak_power(peak_power),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .smoothed_freq(smoothed_freq), .stiffness_index(stiffness_index), .load_class(load_class)
  );

  always #5 clk = ~clk;

  function automatic void flag_error(string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("ERROR at %0t: %s", $time, msg);
    end
  endfunction

  function automatic logic [CLASS_W-1:0] load_class_of(logic [INDEX_W-1:0] idx);
    if (idx >= model_cfg.full_load_threshold) begin
      return CLASS_FULL;
    end else if (idx >= model_cfg.partial_load_threshold) begin
      return CLASS_PARTIAL;
    end
    return CLASS_NON;
  endfunction

  // Gate one estimate, fold it into the running average and rescale the index
  function automatic track_result_t track_estimate(logic [FREQ_W-1:0] f, logic [POWER_W-1:0] p);
    track_result_t r;
    logic [31:0] blend;
    logic [63:0] quotient;
    if (p < model_cfg.power_floor) begin
      r.status = STATUS_LOW_POWER;
    end else if (f < model_cfg.band_low_freq || f > model_cfg.band_high_freq) begin
      r.status = STATUS_OUT_BAND;
    end else begin
      r.status = STATUS_OK;
      if (!trk_primed) begin
        trk_smoothed = f;
        trk_primed = 1'b1;
      end else begin
        blend = (32'(WEIGHT_NEW) * 32'(f) + 32'(WEIGHT_OLD) * 32'(trk_smoothed)
                 + 32'(SMOOTH_ROUND)) >> SMOOTH_SHIFT;
        trk_smoothed = blend[FREQ_W-1:0];
      end
      quotient = (64'(trk_smoothed) * 64'(trk_smoothed) * 64'(INDEX_SCALE))
                 / (64'(model_cfg.healthy_freq) * 64'(model_cfg.healthy_freq));
      trk_index = (quotient > 64'(INDEX_MAX)) ? INDEX_MAX : quotient[INDEX_W-1:0];
    end
    r.freq = trk_smoothed;
    r.index = trk_index;
    r.load_cls = load_class_of(trk_index);
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      flag_error($sformatf("%s expected 0x%0h got 0x%0h", name, want, got));
    end
  endfunction

  function automatic logic [31:0] with_stray_bits(logic [31:0] v, int w);
    logic [31:0] junk;
    junk = $urandom;
    if (w >= 32 || $urandom_range(0, 1) == 0) begin
      return v;
    end
    return (junk << w) | v;
  endfunction

  function automatic cfg_t pick_settings();
    cfg_t s;
    case ($urandom_range(0, 5))
      0: s.power_floor = '0;
      1: s.power_floor = 32'd1;
      2: s.power_floor = '1;
      default: s.power_floor = $urandom >> $urandom_range(0, 31);
    endcase
    if ($urandom_range(0, 7) == 0) begin
      s.band_low_freq = 16'($urandom_range(65535, 20000));
      s.band_high_freq = 16'($urandom_range(19999, 0));
    end else begin
      s.band_low_freq = 16'($urandom_range(12000, 0));
      s.band_high_freq = 16'($urandom_range(65535, s.band_low_freq));
    end
    s.healthy_freq = ($urandom_range(0, 5) == 0) ? 15'($urandom)
                                                  : 15'($urandom_range(31999, 65));
    if ($urandom_range(0, 5) == 0) begin
      s.partial_load_threshold = 12'($urandom);
      s.full_load_threshold = 12'($urandom);
    end else begin
      s.partial_load_threshold = 12'($urandom_range(3200, 0));
      s.full_load_threshold = 12'($urandom_range(3200, s.partial_load_threshold));
    end
    return s;
  endfunction

  task automatic write_reg(input logic [REG_SEL_W-1:0] idx, input logic [DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_POWER_FLOOR:    model_cfg.power_floor = value;
      REG_BAND_LOW:       model_cfg.band_low_freq = value[FREQ_W-1:0];
      REG_BAND_HIGH:      model_cfg.band_high_freq = value[FREQ_W-1:0];
      REG_HEALTHY: begin
        // out-of-range values leave the divisor untouched
        if (value[HEALTH_W-1:0] >= HEALTHY_MIN && value[HEALTH_W-1:0] <= HEALTHY_MAX) begin
          model_cfg.healthy_freq = value[HEALTH_W-1:0];
        end
      end
      REG_FULL_THRESH:    model_cfg.full_load_threshold = value[INDEX_W-1:0];
      REG_PARTIAL_THRESH: model_cfg.partial_load_threshold = value[INDEX_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic program_settings(input cfg_t s);
    write_reg(REG_POWER_FLOOR, s.power_floor);
    write_reg(REG_BAND_LOW, with_stray_bits(32'(s.band_low_freq), FREQ_W));
    write_reg(REG_BAND_HIGH, with_stray_bits(32'(s.band_high_freq), FREQ_W));
    write_reg(REG_HEALTHY, with_stray_bits(32'(s.healthy_freq), HEALTH_W));
    write_reg(REG_FULL_THRESH, with_stray_bits(32'(s.full_load_threshold), INDEX_W));
    write_reg(REG_PARTIAL_THRESH, with_stray_bits(32'(s.partial_load_threshold), INDEX_W));
  endtask

  // Offer one request and return at the edge that takes it
  task automatic send_estimate(input logic [FREQ_W-1:0] f, input logic [POWER_W-1:0] p);
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    peak_freq <= f;
    peak_power <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic finish_batch();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic pick_estimate(output logic [FREQ_W-1:0] f, output logic [POWER_W-1:0] p);
    case ($urandom_range(0, 9))
      0, 1: begin
        f = 16'($urandom);
        p = $urandom;
      end
      2: begin
        f = $urandom_range(0, 1) ? model_cfg.band_low_freq - 16'd1
                                 : model_cfg.band_high_freq + 16'd1;
        p = model_cfg.power_floor;
      end
      3: begin
        f = $urandom_range(0, 1) ? model_cfg.band_low_freq : model_cfg.band_high_freq;
        p = $urandom_range(0, 1) ? model_cfg.power_floor : model_cfg.power_floor - 32'd1;
      end
      default: begin
        if (model_cfg.band_low_freq <= model_cfg.band_high_freq) begin
          f = 16'($urandom_range(model_cfg.band_high_freq, model_cfg.band_low_freq));
        end else begin
          f = 16'($urandom);
        end
        p = $urandom | model_cfg.power_floor;
      end
    endcase
  endtask

  task automatic test_reset_settings();
    // nothing accepted yet: rejections report zero state
    send_estimate(16'd0, 32'd0);
    send_estimate(16'd5120, 32'd0);
    send_estimate(16'd0, 32'hFFFF_FFFF);
    send_estimate(16'hFFFF, 32'd1);
    send_estimate(16'd1279, 32'd1);
    send_estimate(16'd25601, 32'd1);
    // band edges, first one primes the average
    send_estimate(16'd1280, 32'd1);
    send_estimate(16'd25600, 32'hFFFF_FFFF);
    send_estimate(16'd5120, 32'd1);
    send_estimate(16'hAAAA, 32'h5555_5555);
    send_estimate(16'h5555, 32'hAAAA_AAAA);
    finish_batch();
  endtask

  task automatic test_register_extremes();
    write_reg(REG_POWER_FLOOR, 32'hFFFF_FFFF);
    write_reg(REG_BAND_LOW, 32'hFFFF_0000);
    write_reg(REG_BAND_HIGH, 32'hFFFF_FFFF);
    write_reg(REG_HEALTHY, 32'(HEALTHY_MIN));
    write_reg(REG_FULL_THRESH, 32'hFFFF_F000 | 32'(INDEX_MAX));
    write_reg(REG_PARTIAL_THRESH, 32'd0);
    send_estimate(16'hFFFF, 32'hFFFF_FFFE);
    send_estimate(16'hFFFF, 32'hFFFF_FFFF);
    send_estimate(16'h0000, 32'hFFFF_FFFF);
    finish_batch();
    // bad healthy values are dropped; the index holds until the next acceptance
    write_reg(REG_HEALTHY, 32'd64);
    write_reg(REG_HEALTHY, 32'd32000);
    write_reg(REG_HEALTHY, 32'h0001_8000);
    send_estimate(16'd100, 32'd0);
    finish_batch();
    write_reg(REG_HEALTHY, 32'hFFFF_7CFF);
    send_estimate(16'd0, 32'd0);
    finish_batch();
    // full is tested before partial
    write_reg(REG_POWER_FLOOR, 32'd0);
    write_reg(REG_FULL_THRESH, 32'd0);
    write_reg(REG_PARTIAL_THRESH, 32'(INDEX_MAX));
    send_estimate(16'd0, 32'd0);
    finish_batch();
    write_reg(REG_FULL_THRESH, 32'hFFF);
    write_reg(REG_PARTIAL_THRESH, 32'hFFF);
    send_estimate(16'd1000, 32'd5);
    finish_batch();
    // inverted band rejects everything
    write_reg(REG_BAND_LOW, 32'd30000);
    write_reg(REG_BAND_HIGH, 32'd100);
    send_estimate(16'd100, 32'd7);
    send_estimate(16'd30000, 32'd7);
    send_estimate(16'd5000, 32'd7);
    finish_batch();
  endtask

  task automatic test_backpressure();
    logic [FREQ_W-1:0]  f;
    logic [POWER_W-1:0] p;
    program_settings('{power_floor: 32'd0, band_low_freq: 16'd0, band_high_freq: 16'hFFFF,
                       healthy_freq: RST_HEALTHY, full_load_threshold: RST_FULL_THRESH,
                       partial_load_threshold: RST_PARTIAL_THRESH});
    src_gaps = 1'b0;
    sink_gaps = 1'b0;
    hold_req = 150;
    repeat (24) begin
      pick_estimate(f, p);
      send_estimate(f, p);
    end
    finish_batch();
  endtask

  task automatic test_random_traffic(input int n_items, input bit idling);
    logic [FREQ_W-1:0]  f;
    logic [POWER_W-1:0] p;
    program_settings(pick_settings());
    src_gaps = idling;
    sink_gaps = idling;
    repeat (n_items) begin
      pick_estimate(f, p);
      send_estimate(f, p);
    end
    finish_batch();
  endtask

  // Receiver side: long hold-offs on request, otherwise random stall bursts
  always @(posedge clk) begin : sink_ctrl
    logic stall_next;
    stall_next = 1'b0;
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      stall_next = 1'b1;
      hold_left--;
    end else if (sink_gaps) begin
      if (burst_left > 0) begin
        stall_next = 1'b1;
        burst_left--;
      end else if (calm_left > 0) begin
        calm_left--;
      end else if ($urandom_range(0, 2) == 0) begin
        stall_next = 1'b1;
        burst_left = $urandom_range(0, 13);
      end else begin
        calm_left = $urandom_range(1, 40);
      end
    end
    out_stall <= stall_next;
  end

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      pending_results.push_back(track_estimate(peak_freq, peak_power));
    end
  end

  always @(posedge clk) begin : result_check
    track_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        flag_error($sformatf("result with nothing expected: status %0d freq 0x%0h",
                             status, smoothed_freq));
      end else begin
        want = pending_results.pop_front();
        check_field("status", status, want.status);
        check_field("smoothed_freq", smoothed_freq, want.freq);
        check_field("stiffness_index", stiffness_index, want.index);
        check_field("load_class", load_class, want.load_cls);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    model_cfg = '{power_floor: RST_POWER_FLOOR, band_low_freq: RST_BAND_LOW,
                  band_high_freq: RST_BAND_HIGH, healthy_freq: RST_HEALTHY,
                  full_load_threshold: RST_FULL_THRESH,
                  partial_load_threshold: RST_PARTIAL_THRESH};
    trk_smoothed = '0;
    trk_primed = 1'b0;
    trk_index = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_settings();
    test_register_extremes();
    test_backpressure();
    repeat (5) test_random_traffic(170, 1'b1);
    test_random_traffic(150, 1'b0);

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      flag_error($sformatf("%0d results never arrived", pending_results.size()));
    end
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
